// File: rtl/pat2d_pkg.sv
// Shared types, constants and trig table for the 2D point transform.
package pat2d_pkg;

   localparam int REG_WIDTH       = 16;
   localparam int ANGLE_WIDTH     = 9;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int TABLE_FRAC      = 14;

   localparam int COORD_WIDTH_DEFAULT      = 16;
   localparam int FACTOR_FRAC_BITS_DEFAULT = 8;
   localparam int TRIG_FRAC_BITS_DEFAULT   = 14;

   localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN       = 9'd90;
   localparam logic [ANGLE_WIDTH-1:0] HALF_TURN          = 9'd180;
   localparam logic [ANGLE_WIDTH-1:0] THREE_QUARTER_TURN = 9'd270;
   localparam logic [ANGLE_WIDTH-1:0] FULL_TURN          = 9'd360;

   typedef enum logic [1:0] {
      MODE_TRANSLATE = 2'd0,
      MODE_ROTATE    = 2'd1,
      MODE_SCALE     = 2'd2,
      MODE_SHEAR     = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_MODE         = 3'd0,
      REG_CENTER_X     = 3'd1,
      REG_CENTER_Y     = 3'd2,
      REG_AMOUNT_X     = 3'd3,
      REG_AMOUNT_Y     = 3'd4,
      REG_ROTATE_ANGLE = 3'd5
   } reg_index_type;

   // Final right shift applied to the accumulated sum
   typedef enum logic [1:0] {
      SHIFT_NONE   = 2'd0,
      SHIFT_TRIG   = 2'd1,
      SHIFT_FACTOR = 2'd2
   } shift_type;

   typedef struct packed {
      mode_type                       mode;
      logic signed [REG_WIDTH-1:0]    center_x;
      logic signed [REG_WIDTH-1:0]    center_y;
      logic signed [REG_WIDTH-1:0]    amount_x;
      logic signed [REG_WIDTH-1:0]    amount_y;
      logic [ANGLE_WIDTH-1:0]         rotate_angle;
   } cfg_type;

   // round(sin(d deg) * 2^14) for d = 0..90
   localparam int QUARTER_SINE [0:90] = '{
      0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
      2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
      5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
      8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384
   };

   // Width of a multiplier coefficient: trig value or a register value
   function automatic int coef_width(input int trig_frac);
      return (trig_frac + 2 > REG_WIDTH) ? trig_frac + 2 : REG_WIDTH;
   endfunction

   // Sine of a whole-degree angle below two full turns, trig_frac fraction bits
   function automatic int sine_deg(input logic [ANGLE_WIDTH-1:0] angle, input int trig_frac);
      logic [ANGLE_WIDTH-1:0] a;
      logic [6:0]             idx;
      logic                   neg;
      int                     t;
      a = (angle >= FULL_TURN) ? ANGLE_WIDTH'(angle - FULL_TURN) : angle;
      if (a <= QUARTER_TURN) begin
         idx = 7'(a);
         neg = 1'b0;
      end else if (a <= HALF_TURN) begin
         idx = 7'(HALF_TURN - a);
         neg = 1'b0;
      end else if (a <= THREE_QUARTER_TURN) begin
         idx = 7'(a - HALF_TURN);
         neg = 1'b1;
      end else begin
         idx = 7'(FULL_TURN - a);
         neg = 1'b1;
      end
      t = QUARTER_SINE[(idx > 7'd90) ? 7'd90 : idx];
      // Rescale from the table's 14 fraction bits, rounding half up
      if (trig_frac >= TABLE_FRAC) begin
         t = t <<< (trig_frac - TABLE_FRAC);
      end else begin
         t = (t + (1 <<< (TABLE_FRAC - trig_frac - 1))) >>> (TABLE_FRAC - trig_frac);
      end
      return neg ? -t : t;
   endfunction

endpackage

// File: rtl/pat2d_front.sv
// Stage one: offsets from the center, sine and cosine lookup, operand selection.
module pat2d_front #(
   parameter int COORD_WIDTH      = pat2d_pkg::COORD_WIDTH_DEFAULT,
   parameter int FACTOR_FRAC_BITS = pat2d_pkg::FACTOR_FRAC_BITS_DEFAULT,
   parameter int TRIG_FRAC_BITS   = pat2d_pkg::TRIG_FRAC_BITS_DEFAULT,
   localparam int AW     = COORD_WIDTH + 1,
   localparam int COEF_W = pat2d_pkg::coef_width(TRIG_FRAC_BITS),
   localparam int SW     = AW + COEF_W + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pat2d_pkg::cfg_type            cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [AW-1:0]          a0,
   output logic signed [AW-1:0]          a1,
   output logic signed [AW-1:0]          a2,
   output logic signed [AW-1:0]          a3,
   output logic signed [COEF_W-1:0]      b0,
   output logic signed [COEF_W-1:0]      b1,
   output logic signed [COEF_W-1:0]      b2,
   output logic signed [COEF_W-1:0]      b3,
   output logic signed [SW-1:0]          base_x,
   output logic signed [SW-1:0]          base_y,
   output pat2d_pkg::shift_type          shift
);
   import pat2d_pkg::*;

   localparam int CEN_W = (COORD_WIDTH < REG_WIDTH) ? COORD_WIDTH : REG_WIDTH;

   logic                     valid_ff;
   logic signed [AW-1:0]     a0_ff, a1_ff, a2_ff, a3_ff;
   logic signed [AW-1:0]     a0_in, a1_in, a2_in, a3_in;
   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, b3_ff;
   logic signed [COEF_W-1:0] b0_in, b1_in, b2_in, b3_in;
   logic signed [SW-1:0]     base_x_ff, base_y_ff, base_x_in, base_y_in;
   shift_type                shift_ff, shift_in;

   logic signed [AW-1:0]      px, py, cx, cy, dx, dy, bx, by;
   logic signed [COEF_W-1:0]  ax, ay, sin_c, cos_c;
   logic [ANGLE_WIDTH-1:0]    angle_r;

   // Offsets from the center, coordinates widened by one bit
   always_comb begin
      px = AW'(point_x);
      py = AW'(point_y);
      cx = AW'(signed'(cfg.center_x[CEN_W-1:0]));
      cy = AW'(signed'(cfg.center_y[CEN_W-1:0]));
      dx = px - cx;
      dy = py - cy;
      ax = COEF_W'(cfg.amount_x);
      ay = COEF_W'(cfg.amount_y);
   end

   // Fold the angle into one turn, then look up sine and cosine
   always_comb begin
      angle_r = (cfg.rotate_angle >= FULL_TURN) ?
                ANGLE_WIDTH'(cfg.rotate_angle - FULL_TURN) : cfg.rotate_angle;
      sin_c   = COEF_W'(sine_deg(angle_r, TRIG_FRAC_BITS));
      cos_c   = COEF_W'(sine_deg(ANGLE_WIDTH'(angle_r + QUARTER_TURN), TRIG_FRAC_BITS));
   end

   // Pick up to two products per axis and the base term for the mode
   always_comb begin
      a0_in = '0; a1_in = '0; a2_in = '0; a3_in = '0;
      b0_in = '0; b1_in = '0; b2_in = '0; b3_in = '0;
      bx = px;
      by = py;
      shift_in = SHIFT_NONE;
      case (cfg.mode)
         MODE_ROTATE: begin
            a0_in = dx; b0_in = cos_c;
            a1_in = dy; b1_in = -sin_c;
            a2_in = dx; b2_in = sin_c;
            a3_in = dy; b3_in = cos_c;
            bx = cx;
            by = cy;
            shift_in = SHIFT_TRIG;
         end
         MODE_SCALE: begin
            a0_in = dx; b0_in = ax;
            a2_in = dy; b2_in = ay;
            bx = cx;
            by = cy;
            shift_in = SHIFT_FACTOR;
         end
         MODE_SHEAR: begin
            a0_in = dy; b0_in = ax;
            a2_in = dx; b2_in = ay;
            shift_in = SHIFT_FACTOR;
         end
         default: begin
            a0_in = AW'(1); b0_in = ax;
            a2_in = AW'(1); b2_in = ay;
         end
      endcase
   end

   // Base term scaled up to the product's fraction
   always_comb begin
      case (shift_in)
         SHIFT_TRIG: begin
            base_x_in = SW'(bx) <<< TRIG_FRAC_BITS;
            base_y_in = SW'(by) <<< TRIG_FRAC_BITS;
         end
         SHIFT_FACTOR: begin
            base_x_in = SW'(bx) <<< FACTOR_FRAC_BITS;
            base_y_in = SW'(by) <<< FACTOR_FRAC_BITS;
         end
         default: begin
            base_x_in = SW'(bx);
            base_y_in = SW'(by);
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance the stage when it is empty or the next one can take the word
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a0_ff     <= a0_in;
         a1_ff     <= a1_in;
         a2_ff     <= a2_in;
         a3_ff     <= a3_in;
         b0_ff     <= b0_in;
         b1_ff     <= b1_in;
         b2_ff     <= b2_in;
         b3_ff     <= b3_in;
         base_x_ff <= base_x_in;
         base_y_ff <= base_y_in;
         shift_ff  <= shift_in;
      end
   end

   assign out_valid = valid_ff;
   assign a0 = a0_ff;
   assign a1 = a1_ff;
   assign a2 = a2_ff;
   assign a3 = a3_ff;
   assign b0 = b0_ff;
   assign b1 = b1_ff;
   assign b2 = b2_ff;
   assign b3 = b3_ff;
   assign base_x = base_x_ff;
   assign base_y = base_y_ff;
   assign shift  = shift_ff;

endmodule

// File: rtl/pat2d_mac.sv
// Stages two and three: four registered products, then the per-axis sums.
module pat2d_mac #(
   parameter int COORD_WIDTH    = pat2d_pkg::COORD_WIDTH_DEFAULT,
   parameter int TRIG_FRAC_BITS = pat2d_pkg::TRIG_FRAC_BITS_DEFAULT,
   localparam int AW     = COORD_WIDTH + 1,
   localparam int COEF_W = pat2d_pkg::coef_width(TRIG_FRAC_BITS),
   localparam int PW     = AW + COEF_W,
   localparam int SW     = PW + 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [AW-1:0]     a0,
   input  logic signed [AW-1:0]     a1,
   input  logic signed [AW-1:0]     a2,
   input  logic signed [AW-1:0]     a3,
   input  logic signed [COEF_W-1:0] b0,
   input  logic signed [COEF_W-1:0] b1,
   input  logic signed [COEF_W-1:0] b2,
   input  logic signed [COEF_W-1:0] b3,
   input  logic signed [SW-1:0]     base_x,
   input  logic signed [SW-1:0]     base_y,
   input  pat2d_pkg::shift_type     shift,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [SW-1:0]     sum_x,
   output logic signed [SW-1:0]     sum_y,
   output pat2d_pkg::shift_type     sum_shift
);
   import pat2d_pkg::*;

   logic                 prod_valid_ff, sum_valid_ff;
   logic                 prod_ready, sum_ready;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [PW-1:0] p0_in, p1_in, p2_in, p3_in;
   logic signed [SW-1:0] pbase_x_ff, pbase_y_ff;
   shift_type            pshift_ff, sshift_ff;
   logic signed [SW-1:0] sum_x_ff, sum_y_ff, sum_x_in, sum_y_in;

   // Multiply
   always_comb begin
      p0_in = a0 * b0;
      p1_in = a1 * b1;
      p2_in = a2 * b2;
      p3_in = a3 * b3;
   end

   // Accumulate base and two products per axis
   always_comb begin
      sum_x_in = pbase_x_ff + SW'(p0_ff) + SW'(p1_ff);
      sum_y_in = pbase_y_ff + SW'(p2_ff) + SW'(p3_ff);
   end

   assign sum_ready  = !sum_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign in_ready   = prod_ready;

   // Advance valid bits stage by stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         p0_ff      <= p0_in;
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         p3_ff      <= p3_in;
         pbase_x_ff <= base_x;
         pbase_y_ff <= base_y;
         pshift_ff  <= shift;
      end
      if (sum_ready && prod_valid_ff) begin
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sshift_ff <= pshift_ff;
      end
   end

   assign out_valid = sum_valid_ff;
   assign sum_x     = sum_x_ff;
   assign sum_y     = sum_y_ff;
   assign sum_shift = sshift_ff;

endmodule

// File: rtl/pat2d_round.sv
// Stage four: divide by the fraction truncating toward zero, saturate, hold output.
module pat2d_round #(
   parameter int COORD_WIDTH      = pat2d_pkg::COORD_WIDTH_DEFAULT,
   parameter int FACTOR_FRAC_BITS = pat2d_pkg::FACTOR_FRAC_BITS_DEFAULT,
   parameter int TRIG_FRAC_BITS   = pat2d_pkg::TRIG_FRAC_BITS_DEFAULT,
   localparam int SW = COORD_WIDTH + 1 + pat2d_pkg::coef_width(TRIG_FRAC_BITS) + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SW-1:0]          sum_x,
   input  logic signed [SW-1:0]          sum_y,
   input  pat2d_pkg::shift_type          shift,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] new_x,
   output logic signed [COORD_WIDTH-1:0] new_y,
   output logic                          saturated
);
   import pat2d_pkg::*;

   localparam logic signed [SW-1:0] TRIG_MASK   = SW'((64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1);
   localparam logic signed [SW-1:0] FACTOR_MASK = SW'((64'sd1 <<< FACTOR_FRAC_BITS) - 64'sd1);
   localparam logic signed [SW-1:0] NO_BIAS     = '0;
   localparam logic signed [SW-1:0] SAT_HI      = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] SAT_LO      = -SAT_HI - SW'(1);

   logic                          valid_ff;
   logic signed [COORD_WIDTH-1:0] new_x_ff, new_y_ff, new_x_in, new_y_in;
   logic                          sat_ff, sat_in;
   logic signed [SW-1:0]          qx, qy;
   logic                          clip_x, clip_y;

   // Truncate toward zero: bias negative sums before the arithmetic shift
   always_comb begin
      case (shift)
         SHIFT_TRIG: begin
            qx = (sum_x + (sum_x[SW-1] ? TRIG_MASK : NO_BIAS)) >>> TRIG_FRAC_BITS;
            qy = (sum_y + (sum_y[SW-1] ? TRIG_MASK : NO_BIAS)) >>> TRIG_FRAC_BITS;
         end
         SHIFT_FACTOR: begin
            qx = (sum_x + (sum_x[SW-1] ? FACTOR_MASK : NO_BIAS)) >>> FACTOR_FRAC_BITS;
            qy = (sum_y + (sum_y[SW-1] ? FACTOR_MASK : NO_BIAS)) >>> FACTOR_FRAC_BITS;
         end
         default: begin
            qx = sum_x;
            qy = sum_y;
         end
      endcase
   end

   // Clip each axis to the coordinate range
   always_comb begin
      clip_x = (qx > SAT_HI) || (qx < SAT_LO);
      clip_y = (qy > SAT_HI) || (qy < SAT_LO);
      if (qx > SAT_HI) begin
         new_x_in = SAT_HI[COORD_WIDTH-1:0];
      end else if (qx < SAT_LO) begin
         new_x_in = SAT_LO[COORD_WIDTH-1:0];
      end else begin
         new_x_in = qx[COORD_WIDTH-1:0];
      end
      if (qy > SAT_HI) begin
         new_y_in = SAT_HI[COORD_WIDTH-1:0];
      end else if (qy < SAT_LO) begin
         new_y_in = SAT_LO[COORD_WIDTH-1:0];
      end else begin
         new_y_in = qy[COORD_WIDTH-1:0];
      end
      sat_in = clip_x || clip_y;
   end

   assign in_ready = !valid_ff || out_ready;

   // Output register: take a new word when empty or when the current one leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         new_x_ff <= new_x_in;
         new_y_ff <= new_y_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign new_x     = new_x_ff;
   assign new_y     = new_y_ff;
   assign saturated = sat_ff;

endmodule

// File: rtl/point_affine_transform_2d.sv
// Top level of the 2D point transform: configuration registers and the four-stage pipeline.
// Takes one point per clock unless stalled and returns one transformed point per point,
// in order, through the stages of operand selection with sine/cosine lookup, the four
// parallel multipliers, the per-axis sum, then truncation and saturation into the
// output register. Throughput is one word per cycle while rsp_tready stays high; a
// stall on the result side backs up through the stage valid bits to req_tready.
// Configuration writes are always accepted and take effect on points accepted after
// them; write only while no point is in flight.
module point_affine_transform_2d #(
   parameter int COORD_WIDTH      = pat2d_pkg::COORD_WIDTH_DEFAULT,
   parameter int FACTOR_FRAC_BITS = pat2d_pkg::FACTOR_FRAC_BITS_DEFAULT,
   parameter int TRIG_FRAC_BITS   = pat2d_pkg::TRIG_FRAC_BITS_DEFAULT,
   localparam int DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pat2d_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pat2d_pkg::REG_WIDTH-1:0]         csr_wdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [DATA_W-1:0]                       req_tdata,  // point_x, point_y
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [DATA_W-1:0]                       rsp_tdata,  // new_x, new_y
   output logic [0:0]                              rsp_tuser   // saturated
);
   import pat2d_pkg::*;

   localparam int AW     = COORD_WIDTH + 1;
   localparam int COEF_W = coef_width(TRIG_FRAC_BITS);
   localparam int SW     = AW + COEF_W + 2;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   cfg_type cfg_ff;

   logic                          f_valid, f_ready, m_valid, m_ready;
   logic signed [AW-1:0]          a0, a1, a2, a3;
   logic signed [COEF_W-1:0]      b0, b1, b2, b3;
   logic signed [SW-1:0]          base_x, base_y, sum_x, sum_y;
   shift_type                     shift, sum_shift;
   logic signed [COORD_WIDTH-1:0] point_x, point_y, new_x, new_y;
   logic                          saturated;

   assign csr_ready = 1'b1;

   // Register writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODE:         cfg_ff.mode         <= mode_type'(csr_wdata[1:0]);
            REG_CENTER_X:     cfg_ff.center_x     <= csr_wdata;
            REG_CENTER_Y:     cfg_ff.center_y     <= csr_wdata;
            REG_AMOUNT_X:     cfg_ff.amount_x     <= csr_wdata;
            REG_AMOUNT_Y:     cfg_ff.amount_y     <= csr_wdata;
            REG_ROTATE_ANGLE: cfg_ff.rotate_angle <= csr_wdata[ANGLE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign point_x = req_tdata[COORD_WIDTH-1:0];
   assign point_y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

   pat2d_front #(
      .COORD_WIDTH      (COORD_WIDTH),
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
      .TRIG_FRAC_BITS   (TRIG_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .point_x   (point_x),
      .point_y   (point_y),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .a0        (a0),
      .a1        (a1),
      .a2        (a2),
      .a3        (a3),
      .b0        (b0),
      .b1        (b1),
      .b2        (b2),
      .b3        (b3),
      .base_x    (base_x),
      .base_y    (base_y),
      .shift     (shift)
   );

   pat2d_mac #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .a0        (a0),
      .a1        (a1),
      .a2        (a2),
      .a3        (a3),
      .b0        (b0),
      .b1        (b1),
      .b2        (b2),
      .b3        (b3),
      .base_x    (base_x),
      .base_y    (base_y),
      .shift     (shift),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .sum_x     (sum_x),
      .sum_y     (sum_y),
      .sum_shift (sum_shift)
   );

   pat2d_round #(
      .COORD_WIDTH      (COORD_WIDTH),
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
      .TRIG_FRAC_BITS   (TRIG_FRAC_BITS)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .sum_x     (sum_x),
      .sum_y     (sum_y),
      .shift     (sum_shift),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .new_x     (new_x),
      .new_y     (new_y),
      .saturated (saturated)
   );

   assign rsp_tdata = DATA_W'({new_y, new_x});
   assign rsp_tuser = saturated;

   // A clipped word carries a range limit on at least one axis
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && saturated) |->
         (new_x == COORD_MAX || new_x == COORD_MIN ||
          new_y == COORD_MAX || new_y == COORD_MIN))
      else $error("saturated flag without a clipped coordinate");

   // Input backpressure only when every stage is full and the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && f_valid && m_valid))
      else $error("input stalled while the pipeline has room");

   // A mode write lands in the mode register
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == REG_MODE) |=>
         (cfg_ff.mode == mode_type'($past(csr_wdata[1:0]))))
      else $error("mode register did not take the written value");

endmodule

// File: verif/point_affine_transform_2d_checker.sv
// Monitor, predictor and scoreboard for the 2D point transform channels.
module point_affine_transform_2d_checker #(
   parameter int DATA_W = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [pat2d_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pat2d_pkg::REG_WIDTH-1:0]       csr_wdata,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [DATA_W-1:0]                     req_tdata,  // point_x, point_y
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [DATA_W-1:0]                     rsp_tdata,  // new_x, new_y
   input  logic [0:0]                            rsp_tuser,  // saturated
   output int                                    mismatch_count,
   output int                                    results_outstanding
);
   import pat2d_pkg::*;

   localparam int CW = COORD_WIDTH_DEFAULT;
   localparam int FF = FACTOR_FRAC_BITS_DEFAULT;
   localparam int TF = TRIG_FRAC_BITS_DEFAULT;

   typedef struct packed {
      logic signed [CW-1:0] new_x;
      logic signed [CW-1:0] new_y;
      logic                 saturated;
   } point_result_type;

   // Register shadow, written as the block sees the writes
   mode_type                    cfg_mode;
   logic signed [REG_WIDTH-1:0] cfg_center_x;
   logic signed [REG_WIDTH-1:0] cfg_center_y;
   logic signed [REG_WIDTH-1:0] cfg_amount_x;
   logic signed [REG_WIDTH-1:0] cfg_amount_y;
   logic [ANGLE_WIDTH-1:0]      cfg_angle;

   point_result_type expected_points[$];

   // Sine of a whole-degree angle, TF fraction bits, from the quarter-wave table
   function automatic longint sine_whole_deg(input int unsigned deg);
      int unsigned a;
      longint      t;
      logic        neg;
      a   = deg % 360;
      neg = (a > 180);
      if (a > 180) a = a - 180;
      if (a > 90) a = 180 - a;
      t = QUARTER_SINE[a];
      if (TF >= TABLE_FRAC) begin
         t = t <<< (TF - TABLE_FRAC);
      end else begin
         t = (t + (64'sd1 <<< (TABLE_FRAC - TF - 1))) >>> (TABLE_FRAC - TF);
      end
      return neg ? -t : t;
   endfunction

   // Divide by 2^k, rounding toward zero
   function automatic longint shift_toward_zero(input longint s, input int k);
      return (s < 0) ? -((-s) >>> k) : (s >>> k);
   endfunction

   function automatic point_result_type transform_point(input logic signed [CW-1:0] px_in,
                                                        input logic signed [CW-1:0] py_in);
      longint           px, py, cx, cy, ax, ay, dx, dy, s, c, rx, ry, hi, lo;
      point_result_type r;
      px = px_in;
      py = py_in;
      cx = cfg_center_x;
      cy = cfg_center_y;
      ax = cfg_amount_x;
      ay = cfg_amount_y;
      dx = px - cx;
      dy = py - cy;
      case (cfg_mode)
         MODE_TRANSLATE: begin
            rx = px + ax;
            ry = py + ay;
         end
         MODE_ROTATE: begin
            s  = sine_whole_deg(int'(cfg_angle));
            c  = sine_whole_deg(int'(cfg_angle) + 90);
            rx = shift_toward_zero((cx <<< TF) + dx * c - dy * s, TF);
            ry = shift_toward_zero((cy <<< TF) + dx * s + dy * c, TF);
         end
         MODE_SCALE: begin
            rx = shift_toward_zero((cx <<< FF) + dx * ax, FF);
            ry = shift_toward_zero((cy <<< FF) + dy * ay, FF);
         end
         default: begin
            // shear: the y result takes its offset from center_x
            rx = shift_toward_zero((px <<< FF) + ax * dy, FF);
            ry = shift_toward_zero((py <<< FF) + ay * dx, FF);
         end
      endcase
      hi = (64'sd1 <<< (CW - 1)) - 1;
      lo = -hi - 1;
      r.saturated = (rx > hi) || (rx < lo) || (ry > hi) || (ry < lo);
      rx = (rx > hi) ? hi : (rx < lo) ? lo : rx;
      ry = (ry > hi) ? hi : (ry < lo) ? lo : ry;
      r.new_x = rx[CW-1:0];
      r.new_y = ry[CW-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      point_result_type want;
      point_result_type got;
      int               errs;
      errs = 0;
      if (reset) begin
         expected_points.delete();
         cfg_mode     = MODE_TRANSLATE;
         cfg_center_x = '0;
         cfg_center_y = '0;
         cfg_amount_x = '0;
         cfg_amount_y = '0;
         cfg_angle    = '0;
      end else begin
         // Predict with the settings in force before this edge
         if (req_tvalid && req_tready) begin
            expected_points.push_back(transform_point(req_tdata[CW-1:0], req_tdata[2*CW-1:CW]));
         end
         // Track register writes; unknown indexes drop
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:         cfg_mode     = mode_type'(csr_wdata[1:0]);
               REG_CENTER_X:     cfg_center_x = csr_wdata;
               REG_CENTER_Y:     cfg_center_y = csr_wdata;
               REG_AMOUNT_X:     cfg_amount_x = csr_wdata;
               REG_AMOUNT_Y:     cfg_amount_y = csr_wdata;
               REG_ROTATE_ANGLE: cfg_angle    = (csr_wdata[ANGLE_WIDTH-1:0] >= FULL_TURN) ?
                                                ANGLE_WIDTH'(csr_wdata[ANGLE_WIDTH-1:0] - FULL_TURN) :
                                                csr_wdata[ANGLE_WIDTH-1:0];
               default: ;
            endcase
         end
         // Compare each result word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.new_x     = rsp_tdata[CW-1:0];
            got.new_y     = rsp_tdata[2*CW-1:CW];
            got.saturated = rsp_tuser[0];
            if (expected_points.size() == 0) begin
               $error("result word with no point outstanding: tdata=%h tuser=%b",
                      rsp_tdata, rsp_tuser);
               errs++;
            end else begin
               want = expected_points.pop_front();
               if (got.new_x !== want.new_x) begin
                  $error("new_x mismatch: expected %0d, got %0d", want.new_x, got.new_x);
                  errs++;
               end
               if (got.new_y !== want.new_y) begin
                  $error("new_y mismatch: expected %0d, got %0d", want.new_y, got.new_y);
                  errs++;
               end
               if (got.saturated !== want.saturated) begin
                  $error("saturated mismatch: expected %0d, got %0d",
                         want.saturated, got.saturated);
                  errs++;
               end
            end
         end
      end
      mismatch_count      <= mismatch_count + errs;
      results_outstanding <= expected_points.size();
   end

endmodule

// File: verif/tb_point_affine_transform_2d.sv
// Stimulus, reset, stall patterns and verdict for the 2D point transform.
module tb_point_affine_transform_2d;
   import pat2d_pkg::*;

   localparam int CW           = COORD_WIDTH_DEFAULT;
   localparam int DATA_W       = ((2 * CW + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 10;

   // Indexes past the register list; writes there must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] SPARE_INDEX_A = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] SPARE_INDEX_B = 3'd7;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [REG_WIDTH-1:0]       csr_wdata  = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [DATA_W-1:0]          req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [DATA_W-1:0]          rsp_tdata;
   logic [0:0]                 rsp_tuser;

   int mismatch_count;
   int results_outstanding;

   int          burst_left      = 0;
   int          ready_run_left  = 0;
   int          ready_style     = 0;
   int unsigned ready_tick      = 0;
   int          points_sent     = 0;
   int          phase_len;
   logic [15:0] phase_center_x  = '0;
   logic [15:0] phase_center_y  = '0;

   point_affine_transform_2d u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   point_affine_transform_2d_checker #(.DATA_W(DATA_W)) u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tuser           (rsp_tuser),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: runs of always-ready, coin-flip, mostly-ready and long stalls
   always @(posedge clock) begin
      if (ready_run_left == 0) begin
         ready_style    = $urandom_range(0, 3);
         ready_run_left = $urandom_range(20, 200);
      end
      ready_run_left--;
      ready_tick++;
      case (ready_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 9) != 0);
         default: rsp_tready <= (ready_tick % 6 == 0);
      endcase
   end

   // End the run as failed if it hangs
   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Send one point word, with bursts and random gaps in between
   task automatic send_point(input logic [15:0] x, input logic [15:0] y);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted result has come back
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
   endtask

   // Register write word; valid stays high for back-to-back writes
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Program all registers while idle; junk in the unused upper bits
   task automatic load_settings(input mode_type m, input logic [15:0] cx,
                                input logic [15:0] cy, input logic [15:0] ax,
                                input logic [15:0] ay, input logic [8:0] angle,
                                input bit with_spare);
      hold_until_drained();
      if (with_spare) begin
         write_reg(SPARE_INDEX_A, 16'hFFFF);
         write_reg(SPARE_INDEX_B, 16'h8001);
      end
      write_reg(REG_MODE, {14'($urandom), m});
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_AMOUNT_X, ax);
      write_reg(REG_AMOUNT_Y, ay);
      write_reg(REG_ROTATE_ANGLE, {7'($urandom), angle});
      csr_valid      <= 1'b0;
      phase_center_x  = cx;
      phase_center_y  = cy;
   endtask

   function automatic logic [15:0] rand_near(input logic [15:0] base, input int span);
      int v;
      v = int'($signed(base)) + int'($urandom_range(0, 2 * span)) - span;
      return 16'(v);
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h8001;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         4:       return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 3))
         0, 1:    return rand_near(16'h0000, 400);
         2:       return 16'($urandom);
         default: return pick_extreme();
      endcase
   endfunction

   // Q8.8 factors: mostly modest, sometimes near one, sometimes anything
   function automatic logic [15:0] pick_factor();
      case ($urandom_range(0, 5))
         0, 1, 2: return rand_near(16'h0000, 768);
         3:       return rand_near(16'h0100, 64);
         4:       return 16'($urandom);
         default: return pick_extreme();
      endcase
   endfunction

   task automatic send_random_point();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: send_point(rand_near(phase_center_x, 300), rand_near(phase_center_y, 300));
         5, 6, 7:       send_point(16'($urandom), 16'($urandom));
         8:             send_point(pick_extreme(), pick_extreme());
         default:       send_point(pick_extreme(), 16'($urandom));
      endcase
   endtask

   task automatic load_random_settings();
      mode_type m;
      m = mode_type'($urandom_range(0, 3));
      if (m == MODE_SCALE || m == MODE_SHEAR) begin
         load_settings(m, pick_coord(), pick_coord(), pick_factor(), pick_factor(),
                       9'($urandom_range(0, 511)), 1'b0);
      end else begin
         load_settings(m, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       9'($urandom_range(0, 511)), 1'b0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: plain pass-through at the coordinate extremes
      send_point(16'h0000, 16'h0000);
      send_point(16'h8000, 16'h7FFF);
      send_point(16'h7FFF, 16'h8000);

      // Translate by the extreme offsets: clip high on x, low on y
      load_settings(MODE_TRANSLATE, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 9'd0, 1'b0);
      send_point(16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000);

      // Rotate about an off-origin center through the quadrant boundaries
      load_settings(MODE_ROTATE, 16'd100, -16'sd50, 16'h0000, 16'h0000, 9'd0, 1'b0);
      send_point(16'd1100, -16'sd50);
      load_settings(MODE_ROTATE, 16'd100, -16'sd50, 16'h0000, 16'h0000, 9'd90, 1'b0);
      send_point(16'd1100, -16'sd50);
      load_settings(MODE_ROTATE, 16'd100, -16'sd50, 16'h0000, 16'h0000, 9'd270, 1'b0);
      send_point(16'd1100, 16'd777);
      load_settings(MODE_ROTATE, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 9'd180, 1'b0);
      send_point(16'h7FFF, 16'h7FFF);
      // Angles past a full turn wrap back by 360
      load_settings(MODE_ROTATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd405, 1'b0);
      send_point(16'd1000, -16'sd1000);
      load_settings(MODE_ROTATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd511, 1'b0);
      send_point(16'h7FFF, 16'h8000);

      // Scale by extreme factors; writes to unused indexes go first
      load_settings(MODE_SCALE, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 9'd0, 1'b1);
      send_point(16'h0001, 16'h0001);
      send_point(16'h7FFF, 16'h8000);
      send_point(-16'sd3, 16'd5);
      // Unit factor on x, tiny negative on y
      load_settings(MODE_SCALE, 16'd20, -16'sd20, 16'h0100, 16'hFFFF, 9'd0, 1'b0);
      send_point(16'd1000, -16'sd1000);

      // Shear with distinct centers: y result takes center_x
      load_settings(MODE_SHEAR, 16'd10, -16'sd20, 16'h0080, -16'sd384, 9'd0, 1'b0);
      send_point(16'd30, 16'd7);
      send_point(16'h8000, 16'h7FFF);
      send_point(16'h0000, 16'h0000);

      // Random phases, each under freshly drawn settings
      while (points_sent < RANDOM_ITEMS) begin
         load_random_settings();
         phase_len = $urandom_range(20, 120);
         repeat (phase_len) begin
            send_random_point();
            points_sent++;
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
